/* hw/rtl/mtda_pkg.sv */
// Shared types and constants for the MoE token dispatch allocator.
package mtda_pkg;

	localparam int ENTRY_BITS     = 9;
	localparam int PAGE_BITS      = 24;
	localparam int CHIP_BITS      = 7;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;
	localparam int IN_TDATA_BITS  = 72;
	localparam int OUT_TDATA_BITS = 80;

	typedef enum logic [1:0] {
		MODE_ROUTE   = 2'd0,
		MODE_TABLE   = 2'd1,
		MODE_COUNTER = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_NOT_OWNED  = 3'd0,
		ST_UNMAPPED   = 3'd1,
		ST_DROPPED    = 3'd2,
		ST_LOCAL      = 3'd3,
		ST_REMOTE     = 3'd4,
		ST_WRITE_DONE = 3'd5
	} status_t;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNIT_INDEX    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNIT_MASK     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGE_CAPACITY = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHIP_BASE     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHIP_STRIDE   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_OWN_CHIP      = 3'd5;

	typedef struct packed {
		mode_t        mode;
		logic [7:0]   expert;
		logic [6:0]   table_chip;
		logic [23:0]  counter_value;
		logic [4:0]   token_slot;
		logic [15:0]  token_index;
		logic [3:0]   topk_slot;
		logic         new_batch;
	} item_t;

	typedef struct packed {
		logic [5:0]  unit_index;
		logic [5:0]  unit_mask;
		logic [23:0] page_capacity;
		logic [5:0]  chip_base;
		logic [5:0]  chip_stride;
		logic [5:0]  own_chip;
	} cfg_t;

	typedef struct packed {
		status_t               status;
		logic [ENTRY_BITS-1:0] entry_number;
		logic [PAGE_BITS-1:0]  page_index;
		logic [CHIP_BITS-1:0]  dest_chip;
		logic [7:0]            expert_out;
		logic [4:0]            token_slot_out;
		logic [15:0]           token_index_out;
		logic [3:0]            topk_slot_out;
	} result_t;

	typedef struct packed {
		logic tbl_we;
		logic cnt_we;
	} wr_ctl_t;

endpackage

/* hw/rtl/moe_token_dispatch_allocator_unit.sv */
// Top level of the MoE token dispatch allocator: stream ports, tables and pipeline.
//
// Usage: each item on the s_ stream is a route request (one token, top-k slot
// and expert) or a write of the chip table or a page counter, selected by
// s_tuser. Every item yields exactly one result on the m_ stream, with its
// status in m_tuser. Configuration registers are written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// The item and its table reads are registered, and then the result. Throughput:
// one item per cycle while the output is not stalled; the chip table and page
// counter memories are read at the input transfer and written back as the
// item advances, with a write-to-read bypass for consecutive items on one expert.
// Reset: clears the pipeline, the entry numbering and the configuration
// registers (chip_stride to 1, the rest to 0). The table and counters hold
// no reset value and must be written before an expert is routed.
// Stall: when m_tready is low the result register holds, the staged item
// holds, and s_tready drops once both are occupied.
module moe_token_dispatch_allocator_unit #(
	parameter int NUM_EXPERTS  = 256,
	parameter int COUNTER_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mtda_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mtda_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// expert, table_chip, counter_value, token_slot, token_index, topk_slot, new_batch
	input  logic [mtda_pkg::IN_TDATA_BITS-1:0]    s_tdata,
	// mode
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// entry_number, page_index, dest_chip, expert_out, token_slot_out,
	// token_index_out, topk_slot_out
	output logic [mtda_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
	// status
	output logic [2:0]                            m_tuser
);
	import mtda_pkg::*;

	localparam int AW = (NUM_EXPERTS > 1) ? $clog2(NUM_EXPERTS) : 1;
	localparam int XW = (AW > 8) ? AW : 8;

	cfg_t                  cfg_q;
	item_t                 in_item;
	item_t                 item_s1;
	logic                  valid_s1;
	logic [CHIP_BITS-1:0]  rd_chip_s1;
	logic [COUNTER_BITS-1:0] rd_cnt_s1;
	logic [ENTRY_BITS-1:0] entry_q;
	logic                  out_valid_q;
	result_t               result_q;

	result_t               result_c;
	wr_ctl_t               wr_ctl_c;
	logic [COUNTER_BITS-1:0] cnt_wdata_c;
	logic [ENTRY_BITS-1:0] entry_next_c;

	logic                  accept;
	logic                  advance;
	logic                  tbl_we;
	logic                  cnt_we;
	logic [XW-1:0]         rd_ext;
	logic [XW-1:0]         wr_ext;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;

	logic [CHIP_BITS-1:0]    chip_mem [NUM_EXPERTS];
	logic [COUNTER_BITS-1:0] cnt_mem  [NUM_EXPERTS];

	assign in_item.mode          = mode_t'(s_tuser);
	assign in_item.expert        = s_tdata[7:0];
	assign in_item.table_chip    = s_tdata[14:8];
	assign in_item.counter_value = s_tdata[38:15];
	assign in_item.token_slot    = s_tdata[43:39];
	assign in_item.token_index   = s_tdata[59:44];
	assign in_item.topk_slot     = s_tdata[63:60];
	assign in_item.new_batch     = s_tdata[64];

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign rd_ext  = XW'(in_item.expert);
	assign wr_ext  = XW'(item_s1.expert);
	assign rd_addr = rd_ext[AW-1:0];
	assign wr_addr = wr_ext[AW-1:0];
	assign tbl_we  = advance && wr_ctl_c.tbl_we;
	assign cnt_we  = advance && wr_ctl_c.cnt_we;

	mtda_route #(
		.NUM_EXPERTS (NUM_EXPERTS),
		.COUNTER_BITS(COUNTER_BITS)
	) u_route (
		.item      (item_s1),
		.cfg       (cfg_q),
		.rd_chip   (rd_chip_s1),
		.rd_cnt    (rd_cnt_s1),
		.entry_cur (entry_q),
		.result    (result_c),
		.wr_ctl    (wr_ctl_c),
		.cnt_wdata (cnt_wdata_c),
		.entry_next(entry_next_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_index    <= '0;
			cfg_q.unit_mask     <= '0;
			cfg_q.page_capacity <= '0;
			cfg_q.chip_base     <= '0;
			cfg_q.chip_stride   <= 6'd1;
			cfg_q.own_chip      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UNIT_INDEX:    cfg_q.unit_index    <= cfg_data[5:0];
				CFG_UNIT_MASK:     cfg_q.unit_mask     <= cfg_data[5:0];
				CFG_PAGE_CAPACITY: cfg_q.page_capacity <= cfg_data[23:0];
				CFG_CHIP_BASE:     cfg_q.chip_base     <= cfg_data[5:0];
				CFG_CHIP_STRIDE:   cfg_q.chip_stride   <= cfg_data[5:0];
				CFG_OWN_CHIP:      cfg_q.own_chip      <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			chip_mem[wr_addr] <= item_s1.table_chip;
		end
		if (cnt_we) begin
			cnt_mem[wr_addr] <= cnt_wdata_c;
		end
	end

	// read at the input transfer; bypass the write committed at the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			if (tbl_we && (wr_addr == rd_addr)) begin
				rd_chip_s1 <= item_s1.table_chip;
			end else begin
				rd_chip_s1 <= chip_mem[rd_addr];
			end
			if (cnt_we && (wr_addr == rd_addr)) begin
				rd_cnt_s1 <= cnt_wdata_c;
			end else begin
				rd_cnt_s1 <= cnt_mem[rd_addr];
			end
		end
		if (advance) begin
			result_q <= result_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			entry_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				entry_q     <= entry_next_c;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.status;
	assign m_tdata  = {7'd0,
	                   result_q.topk_slot_out,
	                   result_q.token_index_out,
	                   result_q.token_slot_out,
	                   result_q.expert_out,
	                   result_q.dest_chip,
	                   result_q.page_index,
	                   result_q.entry_number};

endmodule

/* hw/rtl/mtda_route.sv */
// Routing decision for one item: ownership, mapping, page allocation and destination, or a table or counter write.
module mtda_route #(
	parameter int NUM_EXPERTS  = 256,
	parameter int COUNTER_BITS = 24
) (
	input  mtda_pkg::item_t                   item,
	input  mtda_pkg::cfg_t                    cfg,
	input  logic [mtda_pkg::CHIP_BITS-1:0]    rd_chip,
	input  logic [COUNTER_BITS-1:0]           rd_cnt,
	input  logic [mtda_pkg::ENTRY_BITS-1:0]   entry_cur,
	output mtda_pkg::result_t                 result,
	output mtda_pkg::wr_ctl_t                 wr_ctl,
	output logic [COUNTER_BITS-1:0]           cnt_wdata,
	output logic [mtda_pkg::ENTRY_BITS-1:0]   entry_next
);
	import mtda_pkg::*;

	logic                  in_range;
	logic                  owned;
	logic                  mapped;
	logic                  full;
	logic                  cnt_max;
	logic [31:0]           cnt32;
	logic [31:0]           cval32;
	logic [11:0]           chip_prod;
	logic [12:0]           chip_sum;
	logic                  chip_match;
	logic [ENTRY_BITS-1:0] entry_base;

	assign in_range   = 32'(item.expert) < 32'(NUM_EXPERTS);
	assign owned      = (item.expert[5:0] & cfg.unit_mask) == cfg.unit_index;
	assign mapped     = !rd_chip[6];
	assign cnt32      = 32'(rd_cnt);
	assign cval32     = 32'(item.counter_value);
	assign full       = cnt32 >= 32'(cfg.page_capacity);
	assign cnt_max    = &rd_cnt;
	assign chip_prod  = 12'(rd_chip[5:0]) * 12'(cfg.chip_stride);
	assign chip_sum   = 13'(cfg.chip_base) + 13'(chip_prod);
	assign chip_match = chip_sum == 13'(cfg.own_chip);
	// new_batch restarts numbering ahead of this item, whatever the mode
	assign entry_base = item.new_batch ? '0 : entry_cur;

	always_comb begin
		result            = '0;
		result.status     = ST_NOT_OWNED;
		result.expert_out = item.expert;
		wr_ctl            = '0;
		cnt_wdata         = rd_cnt + COUNTER_BITS'(1);
		entry_next        = entry_base;
		case (item.mode)
			MODE_TABLE: begin
				result.status = ST_WRITE_DONE;
				wr_ctl.tbl_we = in_range;
			end
			MODE_COUNTER: begin
				result.status = ST_WRITE_DONE;
				wr_ctl.cnt_we = in_range;
				cnt_wdata     = cval32[COUNTER_BITS-1:0];
			end
			MODE_ROUTE: begin
				result.token_slot_out  = item.token_slot;
				result.token_index_out = item.token_index;
				result.topk_slot_out   = item.topk_slot;
				if (!owned) begin
					result.status = ST_NOT_OWNED;
				end else if (!in_range || !mapped) begin
					result.status = ST_UNMAPPED;
				end else begin
					// counter advances even when the token is dropped, saturating at all ones
					wr_ctl.cnt_we = !cnt_max;
					if (full) begin
						result.status = ST_DROPPED;
					end else begin
						result.status       = chip_match ? ST_LOCAL : ST_REMOTE;
						result.entry_number = entry_base;
						result.page_index   = cnt32[PAGE_BITS-1:0];
						result.dest_chip    = (chip_sum > 13'd127) ? 7'd127 : chip_sum[6:0];
						entry_next          = entry_base + ENTRY_BITS'(1);
					end
				end
			end
			default: begin
				result.status = ST_NOT_OWNED;
			end
		endcase
	end

endmodule
